[rtl/core/lru_page_replacement_stack_unit_defines.svh]
// Assertion macros shared by the checker of the LRU page replacement stack unit.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef LRU_PAGE_REPLACEMENT_STACK_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LRUPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LRUPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lrups_pkg.sv]
// Shared types and constants for the LRU page replacement stack unit.
// Depends on nothing; imported by every module of the block.
package lrups_pkg;

   localparam int PAGE_W         = 8;
   localparam int COUNT_W        = 16;
   localparam int OCC_W          = 5;
   localparam int CFG_W          = 5;
   localparam int DEF_MAX_FRAMES = 16;
   localparam int RESET_FRAMES   = 3;

   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Command from the handshake logic to the stack.
   typedef struct packed {
      logic              step;
      logic              clear;
      logic [PAGE_W-1:0] page;
   } lrups_cmd_type;

   // Per-transaction control broadcast to every cell of the row.
   typedef struct packed {
      logic               step;
      logic               hit;
      logic               full_miss;
      logic               room_miss;
      logic [PAGE_W-1:0]  page;
      logic [COUNT_W-1:0] new_count;
   } lrups_cell_ctrl_type;

   // Result of one reference, as it goes to the output register.
   typedef struct packed {
      logic               hit;
      logic               evicted;
      logic [PAGE_W-1:0]  evicted_page;
      logic [COUNT_W-1:0] use_count;
      logic [OCC_W-1:0]   occupied;
   } lrups_result_type;

endpackage

[rtl/core/lrups_cell.sv]
// One slot of the LRU stack: a page number and its use count.
// Depends on lrups_pkg; instantiated in a row by lrups_stack.
module lrups_cell
   import lrups_pkg::*;
#(
   parameter int INDEX  = 0,
   parameter int FILL_W = 5
) (
   input  logic                clock,
   input  lrups_cell_ctrl_type ctrl,
   input  logic [FILL_W-1:0]   fill,
   input  logic                above_in,
   output logic                above_out,
   output logic                match,
   input  logic [PAGE_W-1:0]   upper_page,
   input  logic [COUNT_W-1:0]  upper_count,
   output logic [PAGE_W-1:0]   page_out,
   output logic [COUNT_W-1:0]  count_out
);

   localparam logic [FILL_W-1:0] SLOT    = FILL_W'(INDEX);
   localparam logic [FILL_W-1:0] SLOT_P1 = FILL_W'(INDEX + 1);

   logic [PAGE_W-1:0]  page_ff;
   logic [PAGE_W-1:0]  page_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               filled;
   logic               is_top;
   logic               is_next;
   logic               shift;
   logic               load;

   // Position of this slot relative to the filled part of the stack.
   assign filled  = SLOT < fill;
   assign is_top  = fill == SLOT_P1;
   assign is_next = fill == SLOT;

   // A filled slot matching the page starts the shifting region above it.
   assign match     = filled && (page_ff == ctrl.page);
   assign above_out = above_in | match;

   // Slots at or above the hit (or all on eviction) take their upper neighbor.
   assign shift = ctrl.step && above_out && filled && !is_top;
   assign load  = ctrl.step && ((is_top && (ctrl.hit || ctrl.full_miss)) ||
                                (is_next && ctrl.room_miss));

   always_comb begin
      page_in  = page_ff;
      count_in = count_ff;
      if (load) begin
         page_in  = ctrl.page;
         count_in = ctrl.new_count;
      end else if (shift) begin
         page_in  = upper_page;
         count_in = upper_count;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      count_ff <= count_in;
   end

   assign page_out  = page_ff;
   assign count_out = count_ff;

endmodule

[rtl/core/lrups_stack.sv]
// Row of LRU cells with the fill counter and the hit/eviction decision.
// Depends on lrups_pkg and lrups_cell; instantiated by the top level.
module lrups_stack
   import lrups_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int FILL_W     = $clog2(MAX_FRAMES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  lrups_cmd_type     cmd,
   input  logic [FILL_W-1:0] frames,
   output lrups_result_type  result
);

   logic [FILL_W-1:0]     fill_ff;
   logic [FILL_W-1:0]     fill_in;
   logic [FILL_W-1:0]     fill_after;
   lrups_cell_ctrl_type   ctrl;
   logic [MAX_FRAMES:0]   above;
   logic [MAX_FRAMES-1:0] match;
   logic [PAGE_W-1:0]     pages  [MAX_FRAMES+1];
   logic [COUNT_W-1:0]    counts [MAX_FRAMES+1];
   logic                  any_hit;
   logic                  has_room;
   logic [COUNT_W-1:0]    hit_count;

   // The slot above the last one feeds nothing useful into the row.
   assign pages[MAX_FRAMES]  = '0;
   assign counts[MAX_FRAMES] = '0;

   // Eviction shifts the whole filled part, so it seeds the chain at the bottom.
   assign above[0] = ctrl.full_miss;

   for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_cell
      lrups_cell #(
         .INDEX  (j),
         .FILL_W (FILL_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .fill        (fill_ff),
         .above_in    (above[j]),
         .above_out   (above[j+1]),
         .match       (match[j]),
         .upper_page  (pages[j+1]),
         .upper_count (counts[j+1]),
         .page_out    (pages[j]),
         .count_out   (counts[j])
      );
   end

   // Resident pages are unique, so at most one cell matches.
   always_comb begin
      hit_count = '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
         hit_count = hit_count | (match[j] ? counts[j] : '0);
      end
   end

   assign any_hit  = |match;
   assign has_room = fill_ff < frames;

   // Control broadcast to the row for this transaction.
   always_comb begin
      ctrl.step      = cmd.step;
      ctrl.hit       = any_hit;
      ctrl.full_miss = !any_hit && !has_room;
      ctrl.room_miss = !any_hit && has_room;
      ctrl.page      = cmd.page;
      ctrl.new_count = COUNT_ONE;
      if (any_hit) begin
         ctrl.new_count = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_ONE;
      end
   end

   // Fill level: a miss with free room appends, a frame count write empties.
   assign fill_after = ctrl.room_miss ? fill_ff + FILL_W'(1) : fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.step) begin
         fill_in = fill_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Result of the reference being accepted now.
   always_comb begin
      result.hit          = any_hit;
      result.evicted      = ctrl.full_miss;
      result.evicted_page = ctrl.full_miss ? pages[0] : '0;
      result.use_count    = ctrl.new_count;
      result.occupied     = OCC_W'(fill_after);
   end

endmodule

[rtl/core/lru_page_replacement_stack_unit.sv]
// Top level of the LRU page replacement stack unit: handshakes, frame count
// register and result register. Depends on lrups_pkg and lrups_stack.
//
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_valid/req_stall | req_page_number
//  rsp     | out       | rsp_valid/rsp_stall | rsp_hit, rsp_evicted, rsp_evicted_page,
//          |           |                     | rsp_use_count, rsp_occupied
//  csr     | in        | csr_valid/csr_ready | csr_active_frames
//
// One reference is taken per cycle while req_stall is low; its result appears in the
// output register on the next cycle. The whole decision (search, shift and load of
// the cell row) is done in the cycle of acceptance. The input stalls only while a
// result waits and the output side stalls too. After reset the table is empty and
// three frames are in use.
module lru_page_replacement_stack_unit
   import lrups_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PAGE_W-1:0]  req_page_number,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic               rsp_evicted,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [COUNT_W-1:0] rsp_use_count,
   output logic [OCC_W-1:0]   rsp_occupied,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CFG_W-1:0]   csr_active_frames
);

   localparam int FILL_W = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W  = (CFG_W > FILL_W) ? CFG_W : FILL_W;
   localparam logic [FILL_W-1:0] RESET_FRAMES_USED =
      FILL_W'((RESET_FRAMES > MAX_FRAMES) ? MAX_FRAMES : RESET_FRAMES);

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   lrups_result_type  rsp_result_ff;
   lrups_result_type  result;
   logic [FILL_W-1:0] frames_ff;
   logic [FILL_W-1:0] frames_in;
   logic [CMP_W-1:0]  cfg_ext;
   logic              req_accept;
   logic              csr_write;
   lrups_cmd_type     cmd;

   // Handshakes: the output register frees itself when it is taken.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // Clamp the written frame count to 1..MAX_FRAMES.
   assign cfg_ext = CMP_W'(csr_active_frames);

   always_comb begin
      frames_in = frames_ff;
      if (csr_write) begin
         if (cfg_ext == '0) begin
            frames_in = FILL_W'(1);
         end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
            frames_in = FILL_W'(MAX_FRAMES);
         end else begin
            frames_in = FILL_W'(cfg_ext);
         end
      end
   end

   // Stack command for this cycle.
   always_comb begin
      cmd.step  = req_accept;
      cmd.clear = csr_write;
      cmd.page  = req_page_number;
   end

   lrups_stack #(
      .MAX_FRAMES (MAX_FRAMES),
      .FILL_W     (FILL_W)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .frames (frames_ff),
      .result (result)
   );

   // Output register valid: set on a new transaction, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         frames_ff    <= RESET_FRAMES_USED;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         frames_ff    <= frames_in;
      end
   end

   // Result payload is captured with each accepted transaction.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_result_ff.hit;
   assign rsp_evicted      = rsp_result_ff.evicted;
   assign rsp_evicted_page = rsp_result_ff.evicted_page;
   assign rsp_use_count    = rsp_result_ff.use_count;
   assign rsp_occupied     = rsp_result_ff.occupied;

endmodule

[rtl/core/lrups_checker.sv]
// Port-level checks for the LRU page replacement stack unit, bound to the top.
// Depends on lrups_pkg and lru_page_replacement_stack_unit_defines.svh.
`include "lru_page_replacement_stack_unit_defines.svh"

module lrups_checker
   import lrups_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_hit,
   input logic               rsp_evicted,
   input logic [PAGE_W-1:0]  rsp_evicted_page,
   input logic [COUNT_W-1:0] rsp_use_count,
   input logic [OCC_W-1:0]   rsp_occupied
);

   // A stalled result transaction keeps its valid and its payload.
   `LRUPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted) && $stable(rsp_use_count) && $stable(rsp_evicted_page) && $stable(rsp_occupied), "stalled result changed")

   // Every accepted reference has its result waiting on the next cycle.
   `LRUPS_ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_valid && !req_stall, rsp_valid, "no result after an accepted reference")

   // A reference is either a hit or a miss that may evict, never both.
   `LRUPS_ASSERT_NOW(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted, "hit reported with eviction")

   // Without an eviction no victim page is reported.
   `LRUPS_ASSERT_NOW(a_victim_zero, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_page == '0, "victim page without eviction")

   // A missing page always enters with a use count of one.
   `LRUPS_ASSERT_NOW(a_miss_count, clock, reset, rsp_valid && !rsp_hit, rsp_use_count == COUNT_ONE, "miss with use count other than one")

endmodule

bind lru_page_replacement_stack_unit lrups_checker u_lrups_checker (.*);
